@@ rtl/core/lprl_pkg.sv @@
// Shared types, constants and helpers for the longest-prefix route lookup.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package lprl_pkg;

    localparam int MAX_ROUTES = 32;
    localparam int IDX_W      = $clog2(MAX_ROUTES);
    localparam int CNT_W      = $clog2(MAX_ROUTES + 1);
    localparam int ADDR_W     = 32;
    localparam int PFX_W      = 6;
    localparam int HOP_W      = 8;
    localparam int STATUS_W   = 2;

    localparam logic [PFX_W-1:0]  PFX_MAX  = PFX_W'(ADDR_W);
    localparam logic [ADDR_W-1:0] ALL_ONES = '1;

    localparam logic [STATUS_W-1:0] RSP_ADDED = 2'd0;
    localparam logic [STATUS_W-1:0] RSP_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] RSP_HIT   = 2'd2;
    localparam logic [STATUS_W-1:0] RSP_MISS  = 2'd3;

    localparam logic REQ_ADD    = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [ADDR_W-1:0] address;
        logic [PFX_W-1:0]  prefix_len;
        logic [HOP_W-1:0]  hop_id;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HOP_W-1:0]    match_hop;
        logic [ADDR_W-1:0]   match_network;
        logic [PFX_W-1:0]    match_prefix;
    } rsp_t;

    typedef struct packed {
        logic [ADDR_W-1:0] network;
        logic [PFX_W-1:0]  prefix;
        logic [HOP_W-1:0]  hop;
    } route_t;

    typedef struct packed {
        logic capture;
        logic add_write;
        logic rd_en;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_lookup;
        logic scan_end;
        logic out_free;
    } ctrl_sts_t;

    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PFX_W-1:0] plen);
        logic [PFX_W-1:0] p;
        p = (plen > PFX_MAX) ? PFX_MAX : plen;
        return ~(ALL_ONES >> p);
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/longest_prefix_route_lookup.sv @@
// IPv4 longest-prefix route lookup: request channel s_*, result channel m_*.
// Usage:
//   Each request transaction (s_valid and s_ready high at a clock edge) yields
//   exactly one result transaction on m_valid/m_ready. An add stores the route
//   masked to its prefix length; an add into a full table reports status full.
//   A lookup returns the stored route with the longest matching prefix, the
//   earliest added one on ties, or a miss.
// Sequencing:
//   An add writes the route memory in S_ADD and loads its result into the
//   output register from S_DONE. A lookup walks the N stored routes one per
//   cycle through the route memory read port, then passes S_DRAIN and S_DONE;
//   the block accepts the next request only after the result has been loaded.
// Reset: aresetn is synchronous, active low; it empties the route table and the
//   result register. Route memory contents are not cleared.
// Stall: a finished result waits in the output register while the next request
//   is accepted and processed; the block holds that next result until the
//   waiting one is taken.
// Depends on lprl_pkg, lprl_ctrl and lprl_dp.
`timescale 1ns / 1ps
`default_nettype none

module longest_prefix_route_lookup (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire lprl_pkg::req_t s_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output lprl_pkg::rsp_t      m_data
);

    lprl_pkg::ctrl_cmd_t cmd;
    lprl_pkg::ctrl_sts_t sts;

    lprl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    lprl_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

@@ rtl/core/lprl_ctrl.sv @@
// Sequencing state machine for the route lookup: accept, add, scan, drain, respond.
// Depends on lprl_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module lprl_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire lprl_pkg::ctrl_sts_t sts,
    output lprl_pkg::ctrl_cmd_t     cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ADD   = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = sts.is_lookup ? S_SCAN : S_ADD;
                end
            end
            S_ADD: begin
                cmd.add_write = 1'b1;
                state_next    = S_DONE;
            end
            S_SCAN: begin
                if (sts.scan_end) begin
                    state_next = S_DRAIN;
                end else begin
                    cmd.rd_en = 1'b1;
                end
            end
            S_DRAIN: begin
                state_next = S_DONE;
            end
            S_DONE: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/lprl_dp.sv @@
// Datapath of the route lookup: route memory, scan counter, best-match registers
// and the result register. Depends on lprl_pkg; driven by lprl_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none

module lprl_dp (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire lprl_pkg::req_t     s_data,
    input  wire lprl_pkg::ctrl_cmd_t cmd,
    output lprl_pkg::ctrl_sts_t     sts,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output lprl_pkg::rsp_t          m_data
);

    lprl_pkg::route_t mem [lprl_pkg::MAX_ROUTES];

    lprl_pkg::req_t                     req_reg;
    logic [lprl_pkg::CNT_W-1:0]         count_reg;
    logic [lprl_pkg::CNT_W-1:0]         idx_reg;
    logic                               rd_valid_reg;
    lprl_pkg::route_t                   rd_data_reg;
    logic                               found_reg;
    logic                               rej_reg;
    lprl_pkg::route_t                   best_reg;
    logic                               m_valid_reg;
    lprl_pkg::rsp_t                     m_data_reg;

    logic                               full;
    logic [lprl_pkg::PFX_W-1:0]         plen_sat;
    logic                               hit;
    lprl_pkg::rsp_t                     rsp_next;

    assign full     = (count_reg == lprl_pkg::CNT_W'(lprl_pkg::MAX_ROUTES));
    assign plen_sat = (req_reg.prefix_len > lprl_pkg::PFX_MAX) ? lprl_pkg::PFX_MAX
                                                                : req_reg.prefix_len;
    assign hit = rd_valid_reg
              && ((req_reg.address & lprl_pkg::prefix_mask(rd_data_reg.prefix))
                  == rd_data_reg.network)
              && (!found_reg || (rd_data_reg.prefix > best_reg.prefix));

    assign sts.is_lookup = (s_data.req_type == lprl_pkg::REQ_LOOKUP);
    assign sts.scan_end  = (idx_reg == count_reg);
    assign sts.out_free  = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (cmd.add_write && !full) begin
            mem[count_reg[lprl_pkg::IDX_W-1:0]] <= '{
                network: req_reg.address & lprl_pkg::prefix_mask(plen_sat),
                prefix:  plen_sat,
                hop:     req_reg.hop_id
            };
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[idx_reg[lprl_pkg::IDX_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg <= s_data;
        end
        if (cmd.add_write) begin
            rej_reg <= full;
        end
        if (hit) begin
            best_reg <= rd_data_reg;
        end
        if (cmd.load_out) begin
            m_data_reg <= rsp_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            idx_reg      <= '0;
            rd_valid_reg <= 1'b0;
            found_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cmd.add_write && !full) begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.capture) begin
                idx_reg <= '0;
            end else if (cmd.rd_en) begin
                idx_reg <= idx_reg + 1'b1;
            end
            rd_valid_reg <= cmd.rd_en;
            if (cmd.capture) begin
                found_reg <= 1'b0;
            end else if (hit) begin
                found_reg <= 1'b1;
            end
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        rsp_next = '0;
        if (req_reg.req_type == lprl_pkg::REQ_LOOKUP) begin
            if (found_reg) begin
                rsp_next.status        = lprl_pkg::RSP_HIT;
                rsp_next.match_hop     = best_reg.hop;
                rsp_next.match_network = best_reg.network;
                rsp_next.match_prefix  = best_reg.prefix;
            end else begin
                rsp_next.status = lprl_pkg::RSP_MISS;
            end
        end else begin
            rsp_next.status = rej_reg ? lprl_pkg::RSP_FULL : lprl_pkg::RSP_ADDED;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= lprl_pkg::CNT_W'(lprl_pkg::MAX_ROUTES))
        else $error("route count exceeds table size");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_en |-> (idx_reg < count_reg))
        else $error("scan read beyond written routes");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten before transaction");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_en |=> rd_valid_reg)
        else $error("read data not marked valid after issue");

endmodule

`default_nettype wire
